/* hdl/kst_pkg.sv */
package kst_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 32;
    localparam int OP_W                = 2;
    localparam int KEY_W               = 32;
    localparam int STATUS_W            = 2;
    localparam int ENTRY_W             = 6;

    typedef enum logic [OP_W-1:0] {
        OP_ADD     = 2'd0,
        OP_DEL     = 2'd1,
        OP_DEL_ALL = 2'd2,
        OP_LOOKUP  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_DUP  = 2'd2,
        ST_NONE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_SCAN,
        ENG_DONE
    } eng_state_t;

    typedef struct packed {
        status_t            status;
        logic [ENTRY_W-1:0] entry_count;
        logic               found;
    } kst_result_t;

endpackage

/* hdl/kst_req_if.sv */
interface kst_req_if
    import kst_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [KEY_W-1:0] psid;

    modport source (output valid, output operation, output psid, input ready);
    modport sink (input valid, input operation, input psid, output ready);
endinterface

/* hdl/kst_rsp_if.sv */
interface kst_rsp_if
    import kst_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ENTRY_W-1:0]  entry_count;
    logic                found;

    modport source (output valid, output status, output entry_count, output found,
                    input ready);
    modport sink (input valid, input status, input entry_count, input found,
                  output ready);
endinterface

/* hdl/keyed_set_table_with_capacity_core.sv */
// Bounded set of unique 32-bit service identifiers.
//
// req channel (sink): operation (add, delete, delete all, look up) and psid.
// rsp channel (source): status, entry_count (count after the operation,
// low 6 bits) and found. Every request transfer yields exactly one response.
//
// Keys live in a simple dual-port RAM with a registered read; valid
// marks and the count sit in flops. Add, delete and look up walk the RAM one
// entry per cycle from slot 0 and stop at the first hit, where an add reports
// a duplicate; an add with no hit walks the whole table, takes the lowest free
// slot. Delete all and add to a full table skip the walk.
// A request is registered in the engine, whose result register feeds the
// output register that drives rsp.
// One item is worked at a time; the RAM read port sets the walk rate. The next
// request is taken only after the result has moved on to the output register.
//
// Reset clears every valid mark and the count at once; no clearing pass,
// key RAM contents are don't-care. A response waits in the output register
// while rsp.ready is low; the engine can take and work the next request
// meanwhile and then holds its result until the register frees up.
module keyed_set_table_with_capacity_core
    import kst_pkg::*;
#(
    parameter  int TABLE_DEPTH = TABLE_DEPTH_DEFAULT,
    localparam int IdxW        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
)
(
    input  logic     clk,
    input  logic     rst_n,
    kst_req_if.sink  req,
    kst_rsp_if.source rsp
);

    logic [IdxW-1:0]  rd_addr;
    logic [KEY_W-1:0] rd_data;
    logic             wr_en;
    logic [IdxW-1:0]  wr_addr;
    logic [KEY_W-1:0] wr_data;
    logic             res_valid;
    logic             res_ready;
    kst_result_t      res;

    logic             out_valid_reg, out_valid_next;
    kst_result_t      out_data_reg, out_data_next;

    kst_key_ram #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .clk     (clk),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    kst_engine #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    // output register: free when empty or draining this cycle
    assign res_ready = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_data_reg.status;
    assign rsp.entry_count = out_data_reg.entry_count;
    assign rsp.found       = out_data_reg.found;

    // a hit is only ever reported with status ok
    a_found_ok : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.found |-> res.status == ST_OK)
        else $error("found set with non-ok status");

    // engine never offers a result while taking requests
    a_ready_excl : assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !res_valid)
        else $error("engine ready while holding a result");

    // a result handed to the output register shows up on rsp next cycle
    a_handoff : assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready |=> out_valid_reg && out_data_reg == $past(res))
        else $error("result lost at output register");

    // RAM writes happen only at the end of a walk
    a_wr_scan : assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> res_valid)
        else $error("key write outside a completing add");

endmodule

/* hdl/kst_key_ram.sv */
module kst_key_ram
    import kst_pkg::*;
#(
    parameter  int TABLE_DEPTH = TABLE_DEPTH_DEFAULT,
    localparam int IdxW        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
)
(
    input  logic             clk,
    input  logic [IdxW-1:0]  rd_addr,
    output logic [KEY_W-1:0] rd_data,
    input  logic             wr_en,
    input  logic [IdxW-1:0]  wr_addr,
    input  logic [KEY_W-1:0] wr_data
);

    logic [KEY_W-1:0] mem [TABLE_DEPTH];
    logic [KEY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/kst_engine.sv */
module kst_engine
    import kst_pkg::*;
#(
    parameter  int TABLE_DEPTH = TABLE_DEPTH_DEFAULT,
    localparam int IdxW        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CntW        = $clog2(TABLE_DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    kst_req_if.sink          req,
    output logic [IdxW-1:0]  rd_addr,
    input  logic [KEY_W-1:0] rd_data,
    output logic             wr_en,
    output logic [IdxW-1:0]  wr_addr,
    output logic [KEY_W-1:0] wr_data,
    output logic             res_valid,
    output kst_result_t      res,
    input  logic             res_ready
);

    localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(TABLE_DEPTH);

    eng_state_t       state_reg, state_next;
    op_t              op_reg, op_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [IdxW-1:0]  idx_reg, idx_next;
    logic             free_found_reg, free_found_next;
    logic [IdxW-1:0]  free_idx_reg, free_idx_next;
    logic [CntW-1:0]  cnt_reg, cnt_next;
    logic             valid_reg [TABLE_DEPTH];
    logic             valid_next [TABLE_DEPTH];
    kst_result_t      res_reg, res_next;

    logic             cur_valid;
    logic             match;
    logic             last;
    logic [IdxW-1:0]  slot;
    status_t          st;
    logic             fnd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ENG_IDLE;
            cnt_reg        <= '0;
            free_found_reg <= 1'b0;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            free_found_reg <= free_found_next;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                valid_reg[i] <= valid_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        idx_reg      <= idx_next;
        free_idx_reg <= free_idx_next;
        res_reg      <= res_next;
    end

    // idx_reg names the entry whose key arrives from the RAM this cycle
    assign cur_valid = valid_reg[idx_reg];
    assign match     = cur_valid && (rd_data == key_reg);
    assign last      = (idx_reg == LastIdx);
    assign slot      = free_found_reg ? free_idx_reg : idx_reg;
    assign rd_addr   = (state_reg == ENG_IDLE) ? '0 : IdxW'(idx_reg + 1'b1);
    assign wr_addr   = slot;
    assign wr_data   = key_reg;
    assign req.ready = (state_reg == ENG_IDLE);
    assign res_valid = (state_reg == ENG_DONE);
    assign res       = res_reg;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        idx_next        = idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        cnt_next        = cnt_reg;
        res_next        = res_reg;
        wr_en           = 1'b0;
        st              = ST_OK;
        fnd             = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            valid_next[i] = valid_reg[i];
        end

        unique case (state_reg)
            ENG_IDLE:
            begin
                if (req.valid)
                begin
                    op_next         = op_t'(req.operation);
                    key_next        = req.psid;
                    idx_next        = '0;
                    free_found_next = 1'b0;
                    if (op_t'(req.operation) == OP_DEL_ALL)
                    begin
                        for (int i = 0; i < TABLE_DEPTH; i++)
                        begin
                            valid_next[i] = 1'b0;
                        end
                        cnt_next   = '0;
                        state_next = ENG_DONE;
                    end
                    else if (op_t'(req.operation) == OP_ADD && cnt_reg >= FullCnt)
                    begin
                        st         = ST_FULL;
                        state_next = ENG_DONE;
                    end
                    else
                    begin
                        state_next = ENG_SCAN;
                    end
                end
            end
            ENG_SCAN:
            begin
                if (!cur_valid && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = idx_reg;
                end
                if (match)
                begin
                    state_next = ENG_DONE;
                    unique case (op_reg)
                        OP_ADD:
                        begin
                            st = ST_DUP;
                        end
                        OP_DEL:
                        begin
                            valid_next[idx_reg] = 1'b0;
                            cnt_next            = CntW'(cnt_reg - 1'b1);
                        end
                        default:
                        begin
                            fnd = 1'b1;
                        end
                    endcase
                end
                else if (last)
                begin
                    state_next = ENG_DONE;
                    if (op_reg == OP_ADD)
                    begin
                        if (free_found_reg || !cur_valid)
                        begin
                            wr_en            = 1'b1;
                            valid_next[slot] = 1'b1;
                            cnt_next         = CntW'(cnt_reg + 1'b1);
                        end
                        else
                        begin
                            st = ST_FULL;
                        end
                    end
                    else
                    begin
                        st = ST_NONE;
                    end
                end
                else
                begin
                    idx_next = IdxW'(idx_reg + 1'b1);
                end
            end
            ENG_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ENG_IDLE;
                end
            end
            default:
            begin
                state_next = ENG_IDLE;
            end
        endcase

        if (state_next == ENG_DONE && state_reg != ENG_DONE)
        begin
            res_next.status      = st;
            res_next.entry_count = ENTRY_W'(cnt_next);
            res_next.found       = fnd;
        end
    end

endmodule

/* test/keyed_set_table_with_capacity_core_test.sv */
module keyed_set_table_with_capacity_core_test;
    import kst_pkg::*;

    localparam int DEPTH        = TABLE_DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS = 500;
    // the last requests go out back to back, with the response side always ready
    localparam int QUIET_TAIL   = 60;
    // cap on the set of keys reused for hits, dups and deletes
    localparam int POOL_MAX     = 48;

    // one queued request: operation, key, whether to wait for an empty
    // pipeline first, and idle cycles on the request side ahead of it
    typedef struct {
        op_t              op;
        logic [KEY_W-1:0] id;
        bit               hold;
        int unsigned      gap;
    } req_item_t;

    logic clk;
    logic rst_n;

    kst_req_if req_ch ();
    kst_rsp_if rsp_ch ();

    keyed_set_table_with_capacity_core #(
        .TABLE_DEPTH (DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the table, advanced once per accepted request
    // ------------------------------------------------------------------
    logic [KEY_W-1:0] slot_key  [DEPTH];
    bit               slot_used [DEPTH];
    int unsigned      held_count = 0;

    // Pending requests (filled before reset is released) and the
    // responses still owed by the block, oldest first.
    req_item_t   item_q [$];
    kst_result_t answer_q [$];
    logic [KEY_W-1:0] key_pool [$];

    int unsigned total_items = 0;
    int unsigned req_acc     = 0;
    int unsigned rsp_seen    = 0;
    int unsigned err_count   = 0;
    int unsigned ops_taken   [4];
    int unsigned status_seen [4];

    bit          req_fire   = 1'b0;
    bit          in_tail    = 1'b0;
    bit          loaded     = 1'b0;
    bit          presenting = 1'b0;
    int unsigned idle_left  = 0;
    req_item_t   cur;
    int unsigned stall_left = 0;
    bit          sink_calm  = 1'b0;
    kst_result_t want;

    // Applies one operation to the shadow table and returns the response
    // the block owes for it. Full is checked ahead of duplicate on add;
    // a new key lands in the lowest free slot.
    function automatic kst_result_t predict_result(op_t op, logic [KEY_W-1:0] id);
        kst_result_t r;
        int hit;
        int slot;
        r.status = ST_OK;
        r.found  = 1'b0;
        hit = -1;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (hit < 0 && slot_used[i] && slot_key[i] == id)
                hit = i;
        end
        case (op)
            OP_ADD:
            begin
                if (held_count >= DEPTH)
                    r.status = ST_FULL;
                else if (hit >= 0)
                    r.status = ST_DUP;
                else
                begin
                    slot = -1;
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (slot < 0 && !slot_used[i])
                            slot = i;
                    end
                    if (slot >= 0)
                    begin
                        slot_key[slot]  = id;
                        slot_used[slot] = 1'b1;
                        held_count++;
                    end
                    else
                        r.status = ST_FULL;
                end
            end
            OP_DEL:
            begin
                if (hit >= 0)
                begin
                    slot_used[hit] = 1'b0;
                    if (held_count > 0)
                        held_count--;
                end
                else
                    r.status = ST_NONE;
            end
            OP_DEL_ALL:
            begin
                for (int i = 0; i < DEPTH; i++)
                    slot_used[i] = 1'b0;
                held_count = 0;
            end
            default:
            begin
                if (hit >= 0)
                    r.found = 1'b1;
                else
                    r.status = ST_NONE;
            end
        endcase
        r.entry_count = held_count[ENTRY_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_item(op_t op, logic [KEY_W-1:0] id, bit hold, int unsigned gap);
        req_item_t it;
        it.op   = op;
        it.id   = id;
        it.hold = hold;
        it.gap  = gap;
        item_q.push_back(it);
    endtask

    // corner keys: all zeros, all ones, walking one, walking zero
    function automatic logic [KEY_W-1:0] corner_key();
        logic [KEY_W-1:0] k;
        k = 32'd1 << $urandom_range(0, KEY_W - 1);
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return k;
            default: return ~k;
        endcase
    endfunction

    // mostly keys already used (so hits and dups happen), some corners,
    // some fresh random values
    function automatic logic [KEY_W-1:0] pick_key();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 14 && key_pool.size() > 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        else if (r < 16)
            return corner_key();
        else
            return $urandom();
    endfunction

    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] k;
        k = $urandom();
        key_pool.push_back(k);
        if (key_pool.size() > POOL_MAX)
            void'(key_pool.pop_front());
        return k;
    endfunction

    function automatic int unsigned pick_gap(bit calm);
        if (calm || $urandom_range(0, 2) != 0)
            return 0;
        return $urandom_range(1, 14);
    endfunction

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Request driver: pulls from item_q, drives at the falling edge.
    // A transfer seen by the monitor at the last rising edge frees the
    // slot; the next item is presented right away unless it carries a gap
    // or a hold, so valid stays high across back-to-back transfers.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (req_fire)
            begin
                loaded     = 1'b0;
                presenting = 1'b0;
            end
            if (!loaded && item_q.size() > 0)
            begin
                cur       = item_q.pop_front();
                idle_left = in_tail ? 0 : cur.gap;
                loaded    = 1'b1;
            end
            if (loaded && !presenting)
            begin
                if (idle_left > 0)
                    idle_left--;
                // a held item waits until nothing is owed by the block;
                // in the tail nothing waits
                else if (in_tail || !cur.hold || answer_q.size() == 0)
                    presenting = 1'b1;
            end
            if (presenting)
            begin
                req_ch.valid     <= 1'b1;
                req_ch.operation <= cur.op;
                req_ch.psid      <= cur.id;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Response side backpressure: random stall bursts, with calm stretches
    // toggled at random and none at all in the tail.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ($urandom_range(0, 149) == 0)
                sink_calm = !sink_calm;
            if (in_tail)
            begin
                stall_left = 0;
                rsp_ch.ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!sink_calm && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 14) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: at each rising edge, a request transfer advances the shadow
    // table and queues the owed response; a response transfer is checked
    // field by field against the oldest owed one.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_tail  = item_q.size() < QUIET_TAIL;
            req_fire = req_ch.valid && req_ch.ready;
            if (req_fire)
            begin
                want = predict_result(op_t'(req_ch.operation), req_ch.psid);
                answer_q.push_back(want);
                ops_taken[req_ch.operation]++;
                req_acc++;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                rsp_seen++;
                if (answer_q.size() == 0)
                    report_mismatch($sformatf("response %0d with nothing outstanding",
                                              rsp_seen));
                else
                begin
                    want = answer_q.pop_front();
                    status_seen[rsp_ch.status]++;
                    if (rsp_ch.status !== want.status)
                        report_mismatch($sformatf("response %0d status %s, got %0d",
                                                  rsp_seen, want.status.name(),
                                                  rsp_ch.status));
                    if (rsp_ch.entry_count !== want.entry_count)
                        report_mismatch($sformatf("response %0d entry_count %0d, got %0d",
                                                  rsp_seen, want.entry_count,
                                                  rsp_ch.entry_count));
                    if (rsp_ch.found !== want.found)
                        report_mismatch($sformatf("response %0d found %0d, got %0d",
                                                  rsp_seen, want.found, rsp_ch.found));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned n_random;
        int unsigned fill_len;
        int unsigned seg_len;
        int unsigned r;
        bit          calm;
        bit          first_seg;
        op_t         op;

        // every block input known from time zero
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_ADD;
        req_ch.psid      = '0;
        rsp_ch.ready     = 1'b0;

        // Directed: empty-table misses, delete all on an empty table,
        // corner keys, duplicates, delete then delete again, slot reuse
        // and a look up after delete all.
        push_item(OP_LOOKUP,  32'h0000_0000, 1'b0, 0);
        push_item(OP_DEL,     32'h0000_0000, 1'b0, 0);
        push_item(OP_DEL_ALL, 32'h0000_0000, 1'b0, 0);
        push_item(OP_ADD,     32'h0000_0000, 1'b0, 0);
        push_item(OP_ADD,     32'hFFFF_FFFF, 1'b0, 0);
        push_item(OP_ADD,     32'hFFFF_FFFF, 1'b0, 0);
        push_item(OP_ADD,     32'h0000_0000, 1'b0, 0);
        push_item(OP_LOOKUP,  32'hFFFF_FFFF, 1'b0, 0);
        push_item(OP_LOOKUP,  32'h0000_0000, 1'b0, 0);
        push_item(OP_LOOKUP,  32'h0000_0001, 1'b0, 0);
        push_item(OP_DEL,     32'h0000_0000, 1'b0, 0);
        push_item(OP_DEL,     32'h0000_0000, 1'b0, 0);
        push_item(OP_ADD,     32'h8000_0000, 1'b1, 0);
        push_item(OP_ADD,     32'h7FFF_FFFF, 1'b0, 0);
        push_item(OP_ADD,     32'h5555_5555, 1'b0, 0);
        push_item(OP_ADD,     32'hAAAA_AAAA, 1'b0, 0);
        push_item(OP_DEL,     32'hFFFF_FFFF, 1'b0, 0);
        push_item(OP_ADD,     32'h1234_5678, 1'b0, 0);
        push_item(OP_LOOKUP,  32'hAAAA_AAAA, 1'b0, 0);
        push_item(OP_DEL_ALL, 32'hFFFF_FFFF, 1'b0, 0);
        push_item(OP_LOOKUP,  32'hAAAA_AAAA, 1'b0, 0);
        push_item(OP_ADD,     32'hAAAA_AAAA, 1'b0, 0);

        // Random part, in segments. The first one is always a fill so the
        // full-table cases come early; fills overshoot the capacity so adds
        // (fresh and duplicate) are refused as full.
        n_random  = 0;
        first_seg = 1'b1;
        while (n_random < RANDOM_ITEMS)
        begin
            calm = ($urandom_range(0, 3) == 0);
            r    = first_seg ? 0 : $urandom_range(0, 3);
            if (r == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    push_item(OP_DEL_ALL, $urandom(), first_seg || $urandom_range(0, 2) == 0,
                              pick_gap(calm));
                    n_random++;
                end
                fill_len = DEPTH + $urandom_range(1, 4);
                for (int i = 0; i < fill_len; i++)
                    push_item(OP_ADD, fresh_key(), first_seg && i == 0, pick_gap(calm));
                // full table: a duplicate add still reports full
                for (int i = 0; i < 3; i++)
                    push_item(OP_ADD, pick_key(), 1'b0, pick_gap(calm));
                for (int i = 0; i < 4; i++)
                    push_item(OP_LOOKUP, pick_key(), 1'b0, pick_gap(calm));
                n_random += fill_len + 7;
            end
            else if (r == 3)
            begin
                // drain: deletes of known keys, with look ups in between
                seg_len = $urandom_range(10, 20);
                for (int i = 0; i < seg_len; i++)
                    push_item(($urandom_range(0, 3) == 0) ? OP_LOOKUP : OP_DEL, pick_key(),
                              i == 0 && $urandom_range(0, 2) == 0, pick_gap(calm));
                n_random += seg_len;
            end
            else
            begin
                // churn: all four operations, delete all kept rare
                seg_len = $urandom_range(15, 30);
                for (int i = 0; i < seg_len; i++)
                begin
                    r = $urandom_range(0, 15);
                    if (r < 6)
                        op = OP_ADD;
                    else if (r < 10)
                        op = OP_DEL;
                    else if (r < 11)
                        op = OP_DEL_ALL;
                    else
                        op = OP_LOOKUP;
                    push_item(op, (op == OP_ADD && $urandom_range(0, 2) == 0) ?
                              fresh_key() : pick_key(),
                              i == 0 && $urandom_range(0, 2) == 0, pick_gap(calm));
                end
                n_random += seg_len;
            end
            first_seg = 1'b0;
        end
        total_items = item_q.size();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (req_acc < total_items)
            @(posedge clk);
        while (answer_q.size() != 0)
            @(posedge clk);
        // margin after the last response, longer than a walk over the full table
        repeat (DEPTH + 8) @(posedge clk);

        $display("Covered %0d requests: %0d add, %0d delete, %0d delete all, %0d look up.",
                 req_acc, ops_taken[OP_ADD], ops_taken[OP_DEL], ops_taken[OP_DEL_ALL],
                 ops_taken[OP_LOOKUP]);
        $display("Responses %0d: %0d ok, %0d full, %0d duplicate, %0d absent; %0d mismatches.",
                 rsp_seen, status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_DUP],
                 status_seen[ST_NONE], err_count);
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #5000000;
        $display("Timeout: %0d of %0d requests taken, %0d responses owed.",
                 req_acc, total_items, answer_q.size());
        $display("simulation failed");
        $finish;
    end

endmodule
